### rtl/core/a2q_pkg.sv
`timescale 1ns / 1ps

package a2q_pkg;

	// Quotient bits, one per divider stage
	localparam int unsigned DIV_STAGES = 16;

	// Polynomial coefficients (Q15)
	localparam logic [13:0] COEF_A  = 14'(16'h163f / 2);
	localparam logic [13:0] COEF_B  = 14'(16'h4000 / 2);
	localparam logic [13:0] COEF_AB = COEF_A + COEF_B;

	// Rounding constant for Q15 products
	localparam logic [15:0] RND_HALF = 16'h4000;

	// Octant base angles
	localparam logic [15:0] BASE_ZERO          = 16'h0000;
	localparam logic [15:0] BASE_QUARTER       = 16'h4000;
	localparam logic [15:0] BASE_HALF          = 16'h8000;
	localparam logic [15:0] BASE_THREE_QUARTER = 16'hc000;
	localparam logic [15:0] DIAG_POS           = 16'd8192;
	localparam logic [15:0] DIAG_NEG           = 16'd40960;

	// How the final angle is formed from the polynomial value
	typedef struct packed {
		logic [15:0] base;
		logic        sub;
		logic        use_u;
	} side_t;

	typedef struct packed {
		logic [15:0] num;
		logic [15:0] den;
		logic        neg;
		side_t       side;
	} prep_word_t;

	typedef struct packed {
		logic [15:0] rem;
		logic [15:0] den;
		logic [15:0] quo;
		logic        neg;
		side_t       side;
	} div_word_t;

	typedef struct packed {
		logic [15:0] quo;
		logic        neg;
		side_t       side;
	} ratio_word_t;

endpackage

### rtl/core/atan2_q15_approx_top.sv
`timescale 1ns / 1ps

// Four-quadrant arctangent of a signed Q15 vector (y_value, x_value).
// angle is unsigned, 65536 per full turn.
// Input word: y_value, x_value on in_valid / in_ready.
// Output word: angle on out_valid / out_ready.
// A word passes 21 registers on its way to out_valid (one prep stage,
// sixteen divider stages, four polynomial stages), the first loaded at
// the accepting edge.
// Throughput: one word per cycle while the output is not stalled; each
// divider stage resolves one quotient bit, so a new vector enters every clock.
// Reset (arst_n low) empties every stage; payload registers are not
// cleared and no result appears until a word is accepted.
// When the receiver stalls, the output stage holds its word and the
// stages behind it keep moving until they fill up; in_ready drops only
// once every stage holds a word. Nothing is lost or repeated.
// The block keeps no state between words.
module atan2_q15_approx_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] y_value,
	input  logic signed [15:0] x_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        angle
);
	import a2q_pkg::*;

	logic        prep_v;
	prep_word_t  prep_word;
	logic        prep_en;
	logic        div_v;
	ratio_word_t div_word;
	logic        div_en;
	logic        poly_en;

	a2q_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.y_value  (y_value),
		.x_value  (x_value),
		.en_in    (div_en),
		.en_out   (prep_en),
		.v_s1     (prep_v),
		.word_s1  (prep_word)
	);

	a2q_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (prep_v),
		.word_in   (prep_word),
		.en_in     (poly_en),
		.en_out    (div_en),
		.v_out     (div_v),
		.ratio_out (div_word)
	);

	a2q_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (div_v),
		.ratio_in  (div_word),
		.out_ready (out_ready),
		.en_out    (poly_en),
		.out_valid (out_valid),
		.angle     (angle)
	);

	assign in_ready = prep_en;

`ifndef NO_ASSERTIONS
	// Input may only be held off by a stalled, full output
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without output stall");

	// Numerator never exceeds denominator on the polynomial paths
	a_prep_order: assert property (@(posedge clk) disable iff (!arst_n)
		(prep_v && prep_word.side.use_u) |-> (prep_word.num <= prep_word.den))
		else $error("prep numerator larger than denominator");

	// Quotient reaches 1.0 only for a negative ratio of exactly -1
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(div_v && div_word.side.use_u && div_word.quo[15]) |->
		(div_word.neg && (div_word.quo[14:0] == 15'd0)))
		else $error("quotient out of range");
`endif

endmodule

### rtl/core/a2q_prep.sv
`timescale 1ns / 1ps

module a2q_prep (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [15:0]  y_value,
	input  logic signed [15:0]  x_value,
	input  logic                en_in,
	output logic                en_out,
	output logic                v_s1,
	output a2q_pkg::prep_word_t word_s1
);
	import a2q_pkg::*;

	logic [15:0] ax;
	logic [15:0] ay;
	prep_word_t  nxt;

	// Magnitudes; full-scale negative maps to 0x8000
	assign ax = x_value[15] ? (~x_value + 16'd1) : x_value;
	assign ay = y_value[15] ? (~y_value + 16'd1) : y_value;

	// Pick the smaller magnitude as numerator and the octant base
	always_comb begin
		nxt.neg = x_value[15] ^ y_value[15];
		if (x_value == y_value) begin
			nxt.num        = ax;
			nxt.den        = ay;
			nxt.side.sub   = 1'b0;
			nxt.side.use_u = 1'b0;
			if (y_value == 16'sd0)
				nxt.side.base = BASE_ZERO;
			else if (y_value[15])
				nxt.side.base = DIAG_NEG;
			else
				nxt.side.base = DIAG_POS;
		end else if (ax <= ay) begin
			nxt.num        = ax;
			nxt.den        = ay;
			nxt.side.sub   = 1'b1;
			nxt.side.use_u = 1'b1;
			nxt.side.base  = y_value[15] ? BASE_THREE_QUARTER : BASE_QUARTER;
		end else begin
			nxt.num        = ay;
			nxt.den        = ax;
			nxt.side.sub   = 1'b0;
			nxt.side.use_u = 1'b1;
			nxt.side.base  = x_value[15] ? BASE_HALF : BASE_ZERO;
		end
	end

	assign en_out = !v_s1 || en_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_out) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			word_s1 <= nxt;
		end
	end

endmodule

### rtl/core/a2q_divider.sv
`timescale 1ns / 1ps

module a2q_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_in,
	input  a2q_pkg::prep_word_t   word_in,
	input  logic                  en_in,
	output logic                  en_out,
	output logic                  v_out,
	output a2q_pkg::ratio_word_t  ratio_out
);
	import a2q_pkg::*;

	// Stage k resolves quotient bit DIV_STAGES-1-k
	logic      v_sk    [DIV_STAGES];
	div_word_t word_sk [DIV_STAGES];
	logic      en      [DIV_STAGES+1];

	assign en[DIV_STAGES] = en_in;
	assign en_out         = en[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic        v_src;
		logic [16:0] t;
		logic [15:0] den;
		logic [15:0] quo;
		logic        neg;
		side_t       side;
		logic [16:0] diff;
		logic        bit_q;

		if (k == 0) begin : g_first
			assign v_src = v_in;
			assign t     = {1'b0, word_in.num};
			assign den   = word_in.den;
			assign quo   = '0;
			assign neg   = word_in.neg;
			assign side  = word_in.side;
		end else begin : g_next
			assign v_src = v_sk[k-1];
			assign t     = {word_sk[k-1].rem, 1'b0};
			assign den   = word_sk[k-1].den;
			assign quo   = word_sk[k-1].quo;
			assign neg   = word_sk[k-1].neg;
			assign side  = word_sk[k-1].side;
		end

		// Trial subtract; no borrow means the bit is set
		assign diff  = t - {1'b0, den};
		assign bit_q = !diff[16];

		assign en[k] = !v_sk[k] || en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (en[k]) begin
				v_sk[k] <= v_src;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				word_sk[k].rem  <= bit_q ? diff[15:0] : t[15:0];
				word_sk[k].den  <= den;
				word_sk[k].quo  <= {quo[DIV_STAGES-2:0], bit_q};
				word_sk[k].neg  <= neg;
				word_sk[k].side <= side;
			end
		end
	end

	assign v_out          = v_sk[DIV_STAGES-1];
	assign ratio_out.quo  = word_sk[DIV_STAGES-1].quo;
	assign ratio_out.neg  = word_sk[DIV_STAGES-1].neg;
	assign ratio_out.side = word_sk[DIV_STAGES-1].side;

endmodule

### rtl/core/a2q_poly.sv
`timescale 1ns / 1ps

module a2q_poly (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  v_in,
	input  a2q_pkg::ratio_word_t  ratio_in,
	input  logic                  out_ready,
	output logic                  en_out,
	output logic                  out_valid,
	output logic [15:0]           angle
);
	import a2q_pkg::*;

	logic en_s1, en_s2, en_s3, en_s4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [29:0]        p1_s1;
	logic [15:0]        quo_s1;
	logic               neg_s1;
	side_t              side_s1;

	logic [13:0]        c_s2;
	logic signed [15:0] r_s2;
	side_t              side_s2;

	logic signed [30:0] p2_s3;
	side_t              side_s3;

	logic signed [30:0] np;
	logic [15:0]        add1;
	logic signed [30:0] sum1;
	logic [15:0]        corr;
	logic [15:0]        csum;
	logic signed [30:0] p2;
	logic [15:0]        add2;
	logic [31:0]        sum2;
	logic [15:0]        u;
	logic [15:0]        ang;

	// Stall chain: a stage moves when empty or when the next one moves
	assign en_s4  = !v_s4 || out_ready;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;
	assign en_out = en_s1;

	// Correction term: A * (-|r|), rounded, then added to A + B
	assign np   = -$signed({1'b0, p1_s1});
	assign add1 = (np[15:0] == RND_HALF) ? 16'd0 : RND_HALF;
	assign sum1 = np + $signed({15'd0, add1});
	assign corr = sum1[30:15];
	assign csum = {2'b00, COEF_AB} + corr;

	// Main product c * r, signed Q15
	assign p2   = $signed({1'b0, c_s2}) * r_s2;

	// Round and rotate into the octant
	assign add2 = (p2_s3[15:0] == RND_HALF) ? 16'd0 : RND_HALF;
	assign sum2 = {p2_s3[30], p2_s3} + {16'd0, add2};
	assign u    = sum2[30:15];

	always_comb begin
		if (!side_s3.use_u)
			ang = side_s3.base;
		else if (side_s3.sub)
			ang = side_s3.base - u;
		else
			ang = side_s3.base + u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= v_in;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p1_s1   <= 30'(ratio_in.quo) * 30'(COEF_A);
			quo_s1  <= ratio_in.quo;
			neg_s1  <= ratio_in.neg;
			side_s1 <= ratio_in.side;
		end
		if (en_s2) begin
			c_s2    <= csum[13:0];
			r_s2    <= neg_s1 ? (~quo_s1 + 16'd1) : quo_s1;
			side_s2 <= side_s1;
		end
		if (en_s3) begin
			p2_s3   <= p2;
			side_s3 <= side_s2;
		end
		if (en_s4) begin
			angle   <= ang;
		end
	end

	assign out_valid = v_s4;

endmodule
